### rtl/rpn_pkg.sv
// Package for the postfix stack machine: widths, operation and error codes,
// controller command/status types. No dependencies.
`timescale 1ns / 1ps
package rpn_pkg;
  localparam int STACK_DEPTH = 128;
  localparam int VAR_COUNT   = 256;
  localparam int WORD_WIDTH  = 32;
  localparam int PC_WIDTH    = 16;
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int VA_W  = $clog2(VAR_COUNT);
  localparam int DCW   = $clog2(WORD_WIDTH + 1);

  localparam logic [4:0] OP_PUSHL = 5'd0,  OP_PUSHV = 5'd1,  OP_NOT = 5'd2;
  localparam logic [4:0] OP_OR    = 5'd3,  OP_AND   = 5'd4,  OP_JMP = 5'd5;
  localparam logic [4:0] OP_JF    = 5'd6,  OP_WRITE = 5'd7,  OP_READ = 5'd8;
  localparam logic [4:0] OP_ADD   = 5'd9,  OP_MUL   = 5'd10, OP_SUB = 5'd11;
  localparam logic [4:0] OP_DIV   = 5'd12, OP_EQ    = 5'd13, OP_LT  = 5'd14;
  localparam logic [4:0] OP_GT    = 5'd15, OP_LE    = 5'd16, OP_GE  = 5'd17;
  localparam logic [4:0] OP_NE    = 5'd18, OP_ASSIGN = 5'd19, OP_MOD = 5'd20;

  localparam logic [2:0] ERR_OK = 3'd0, ERR_UNASSIGNED = 3'd1, ERR_DIVZERO = 3'd2;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd3, ERR_OVERFLOW = 3'd4, ERR_HALT = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch input and issue stack/variable reads
    logic check;   // operands valid: evaluate
    logic div_go;  // start divider
    logic commit;  // write back state, load result
  } rpn_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_div;
    logic div_busy;
  } rpn_sts_t;
endpackage

### rtl/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/rpn_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_div import rpn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] dividend,
  input  logic [WORD_WIDTH-1:0] divisor,
  output logic                  busy,
  output logic [WORD_WIDTH-1:0] quot,
  output logic [WORD_WIDTH-1:0] rem
);
  logic [DCW-1:0]        cnt_r;
  logic [WORD_WIDTH-1:0] q_r, rm_r, d_r;
  logic [WORD_WIDTH:0]   trial;

  assign trial = {rm_r, q_r[WORD_WIDTH-1]} - {1'b0, d_r};
  assign busy  = (cnt_r != '0);
  assign quot  = q_r;
  assign rem   = rm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DCW'(WORD_WIDTH);
      q_r   <= dividend;
      rm_r  <= '0;
      d_r   <= divisor;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
      if (!trial[WORD_WIDTH]) begin
        rm_r <= trial[WORD_WIDTH-1:0];
        q_r  <= {q_r[WORD_WIDTH-2:0], 1'b1};
      end else begin
        rm_r <= {rm_r[WORD_WIDTH-2:0], q_r[WORD_WIDTH-1]};
        q_r  <= {q_r[WORD_WIDTH-2:0], 1'b0};
      end
    end
  end
endmodule

### rtl/rpn_ctrl.sv
// Controller state machine: sequences load, check, divide and commit.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_ctrl import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  rpn_sts_t sts,
  output rpn_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_DIV = 3'd2, S_DWAIT = 3'd3;
  localparam logic [2:0] S_CMT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       take;

  // accept only in idle, when the result slot is free or draining this cycle
  assign in_stall  = (state_r != S_IDLE) || (ov_r && out_stall);
  assign take      = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && out_stall;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.check = 1'b1;
        if (sts.is_div) begin
          cmd.div_go = 1'b1;
          state_nxt  = S_DIV;
        end else begin
          state_nxt  = S_CMT;
        end
      end
      // evaluated step is registered: write back and load the result
      S_CMT: begin
        cmd.commit = 1'b1;
        ov_nxt     = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DIV: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (!sts.div_busy) begin
          cmd.commit = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

### rtl/rpn_dp.sv
// Datapath: operand stack and variable RAMs, ALU, divider, result register.
// Depends on rpn_pkg, rpn_ram, rpn_div.
`timescale 1ns / 1ps
module rpn_dp import rpn_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rpn_cmd_t                    cmd,
  output rpn_sts_t                    sts,
  input  logic [4:0]                  in_mode,
  input  logic signed [31:0]          in_operand,
  input  logic signed [31:0]          in_read_value,
  output logic [15:0]                 out_next_pc,
  output logic                        out_write_valid,
  output logic signed [31:0]          out_write_value,
  output logic [2:0]                  out_error_code
);
  localparam logic [WORD_WIDTH-1:0] WSIGN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  logic [4:0]            mode_r;
  logic [WORD_WIDTH-1:0] opnd_r, rdv_r;
  logic [SP_W-1:0]       sp_r;
  logic [PC_WIDTH-1:0]   pc_r;
  logic                  halt_r;
  logic [VAR_COUNT-1:0]  asg_r;
  logic [WORD_WIDTH-1:0] a, b, vdat;
  logic [2:0]            err_r;
  logic [PC_WIDTH-1:0]   nxt_r;
  logic                  push_r;
  logic [WORD_WIDTH-1:0] res_r;
  logic                  sneg_r, bneg_r;
  logic [VA_W-1:0]       vi_r;
  logic [SP_W-1:0]       np_r;

  // stored words: top and next-to-top stack entries through two RAM copies
  logic [SP_W-1:0]       sp_m1, sp_m2;
  logic                  st_we, var_we;
  logic [SA_W-1:0]       st_wa;
  logic [WORD_WIDTH-1:0] st_wd, var_wd;
  logic [VA_W-1:0]       var_ra;
  logic [WORD_WIDTH-1:0] opnd_w;

  assign sp_m1  = sp_r - SP_W'(1);
  assign sp_m2  = sp_r - SP_W'(2);
  assign opnd_w = WORD_WIDTH'(in_operand);
  assign var_ra = opnd_w[VA_W-1:0];

  rpn_ram #(.WIDTH(WORD_WIDTH), .DEPTH(STACK_DEPTH)) u_st_a (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
    .raddr(sp_m1[SA_W-1:0]), .rdata(a));
  rpn_ram #(.WIDTH(WORD_WIDTH), .DEPTH(STACK_DEPTH)) u_st_b (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
    .raddr(sp_m2[SA_W-1:0]), .rdata(b));
  rpn_ram #(.WIDTH(WORD_WIDTH), .DEPTH(VAR_COUNT)) u_var (
    .clk(clk), .we(var_we), .waddr(vi_r), .wdata(var_wd),
    .raddr(var_ra), .rdata(vdat));

  // divider on magnitudes
  logic                  dbusy;
  logic [WORD_WIDTH-1:0] quo, rmd, ma, mb;
  assign ma = a[WORD_WIDTH-1] ? -a : a;
  assign mb = b[WORD_WIDTH-1] ? -b : b;
  rpn_div u_div (.clk(clk), .rst_n(rst_n), .start(cmd.div_go), .dividend(mb),
    .divisor(ma), .busy(dbusy), .quot(quo), .rem(rmd));

  assign sts.div_busy = dbusy;

  // pops/push per operation
  logic [1:0] np_c;
  logic       push_c;
  always_comb begin
    case (mode_r)
      OP_PUSHL, OP_PUSHV: np_c = 2'd0;
      OP_NOT, OP_JMP, OP_WRITE, OP_READ: np_c = 2'd1;
      default: np_c = 2'd2;
    endcase
    push_c = (mode_r <= OP_AND) || (mode_r >= OP_ADD && mode_r <= OP_NE) ||
             (mode_r == OP_MOD);
  end

  // checks and combinational (non-divider) results
  logic [2:0]            err_c;
  logic [WORD_WIDTH-1:0] r_c, vsel;
  logic [PC_WIDTH-1:0]   nxt_c;
  logic                  lt_ba, lt_ab, vbad;
  logic [WORD_WIDTH-1:0] prod;
  assign lt_ba = ((b ^ WSIGN) < (a ^ WSIGN));
  assign lt_ab = ((a ^ WSIGN) < (b ^ WSIGN));
  assign prod  = b * a;
  always_comb begin
    vsel = (mode_r == OP_PUSHV) ? opnd_r : (mode_r == OP_READ) ? a : b;
    vbad = vsel[WORD_WIDTH-1] || (vsel >= WORD_WIDTH'(VAR_COUNT));
    err_c = ERR_OK;
    if (halt_r || mode_r > OP_MOD)                          err_c = ERR_HALT;
    else if (sp_r < SP_W'(np_c))                             err_c = ERR_UNDERFLOW;
    else if ((sp_r - SP_W'(np_c) + SP_W'(push_c)) > SP_W'(STACK_DEPTH))
                                                             err_c = ERR_OVERFLOW;
    else if (mode_r == OP_PUSHV && (vbad || !asg_r[vsel[VA_W-1:0]]))
                                                             err_c = ERR_UNASSIGNED;
    else if ((mode_r == OP_READ || mode_r == OP_ASSIGN) && vbad)
                                                             err_c = ERR_UNASSIGNED;
    else if ((mode_r == OP_DIV || mode_r == OP_MOD) && a == '0)
                                                             err_c = ERR_DIVZERO;
    nxt_c = pc_r + PC_WIDTH'(1);
    if (mode_r == OP_JMP || (mode_r == OP_JF && b == '0)) nxt_c = a[PC_WIDTH-1:0];
    case (mode_r)
      OP_PUSHL: r_c = opnd_r;
      OP_PUSHV: r_c = vdat;
      OP_NOT:   r_c = WORD_WIDTH'(a == '0);
      OP_OR:    r_c = WORD_WIDTH'(a != '0 || b != '0);
      OP_AND:   r_c = WORD_WIDTH'(a != '0 && b != '0);
      OP_WRITE: r_c = a;
      OP_ADD:   r_c = b + a;
      OP_MUL:   r_c = prod;
      OP_SUB:   r_c = b - a;
      OP_EQ:    r_c = WORD_WIDTH'(b == a);
      OP_LT:    r_c = WORD_WIDTH'(lt_ba);
      OP_GT:    r_c = WORD_WIDTH'(lt_ab);
      OP_LE:    r_c = WORD_WIDTH'(!lt_ab);
      OP_GE:    r_c = WORD_WIDTH'(!lt_ba);
      OP_NE:    r_c = WORD_WIDTH'(b != a);
      default:  r_c = '0;
    endcase
  end

  assign sts.is_div   = (err_c == ERR_OK) && (mode_r == OP_DIV || mode_r == OP_MOD);

  // commit: stack/variable write-back
  logic [WORD_WIDTH-1:0] fin_r;
  logic [SP_W-1:0]       sp_new;
  assign fin_r  = (mode_r == OP_DIV) ? (sneg_r ? -quo : quo) :
                  (mode_r == OP_MOD) ? (bneg_r ? -rmd : rmd) : res_r;
  assign sp_new = sp_r - np_r;
  assign st_we  = cmd.commit && err_r == ERR_OK && push_r;
  assign st_wa  = sp_new[SA_W-1:0];
  assign st_wd  = fin_r;
  assign var_we = cmd.commit && err_r == ERR_OK &&
                  (mode_r == OP_READ || mode_r == OP_ASSIGN);
  assign var_wd = (mode_r == OP_READ) ? rdv_r : res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      pc_r   <= '0;
      halt_r <= 1'b0;
      asg_r  <= '0;
    end else if (cmd.commit) begin
      if (err_r != ERR_OK) begin
        halt_r <= 1'b1;
      end else begin
        sp_r <= sp_new + SP_W'(push_r);
        pc_r <= nxt_r;
        if (var_we) asg_r[vi_r] <= 1'b1;
      end
    end
  end

  // operand latch and evaluated-step register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      opnd_r <= opnd_w;
      rdv_r  <= WORD_WIDTH'(in_read_value);
    end
    if (cmd.check) begin
      err_r  <= err_c;
      nxt_r  <= nxt_c;
      push_r <= push_c;
      np_r   <= SP_W'(np_c);
      res_r  <= (mode_r == OP_ASSIGN) ? a : r_c;
      vi_r   <= vsel[VA_W-1:0];
      sneg_r <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
      bneg_r <= b[WORD_WIDTH-1];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_error_code  <= err_r;
      out_next_pc     <= 16'((err_r == ERR_OK) ? nxt_r : pc_r);
      out_write_valid <= (err_r == ERR_OK) && mode_r == OP_WRITE;
      out_write_value <= ((err_r == ERR_OK) && mode_r == OP_WRITE) ? 32'(res_r) : '0;
    end
  end
endmodule

### rtl/rpn_stack_machine_execute_top.sv
// Postfix stack machine: executes one instruction per input transfer and
// returns one result transfer. Each instruction goes from accept to result
// through a RAM read of the two stack operands and the variable, an evaluate
// step and a commit step that loads the result register; divide and modulo
// run the one-bit-per-cycle divider before commit. The next instruction is
// taken once the last has committed and the result register is free or being
// emptied. After an error the block stays halted and reports error 5 until reset.
`timescale 1ns / 1ps
module rpn_stack_machine_execute_top import rpn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_mode,
  input  logic signed [31:0] in_operand,
  input  logic signed [31:0] in_read_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_next_pc,
  output logic               out_write_valid,
  output logic signed [31:0] out_write_value,
  output logic [2:0]         out_error_code
);
  rpn_cmd_t cmd;
  rpn_sts_t sts;

  rpn_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

  rpn_dp u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_mode(in_mode),
    .in_operand(in_operand), .in_read_value(in_read_value),
    .out_next_pc(out_next_pc), .out_write_valid(out_write_valid),
    .out_write_value(out_write_value), .out_error_code(out_error_code));
endmodule

### dv/testbench.sv
// Testbench for the postfix stack machine: random and directed instruction
// streams against a predictor, with random idling on both channels.
// Depends on rpn_pkg and rpn_stack_machine_execute_top.
`timescale 1ns / 1ps
module testbench;
  import rpn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 360;
  localparam int FILL_AT = 60;

  typedef struct {
    logic [15:0] next_pc;
    logic        write_valid;
    logic [31:0] write_value;
    logic [2:0]  error_code;
  } exec_result_t;

  // Predicts each instruction's result and compares it with the block's output
  class rpn_result_tracker;
    logic [31:0]  stack_words [STACK_DEPTH];
    int           depth;
    logic [31:0]  var_words [VAR_COUNT];
    bit           var_set [VAR_COUNT];
    logic [15:0]  pc;
    bit           halted;
    exec_result_t expected_results [$];
    int           fails;
    int           n_checked;
    int           n_writes;

    function new();
      depth = 0;
      pc = '0;
      halted = 0;
      fails = 0;
      n_checked = 0;
      n_writes = 0;
      foreach (var_set[k]) var_set[k] = 0;
    endfunction

    // variable index, or -1 when negative or past the table
    function int var_slot(logic [31:0] v);
      if (v[31] || v >= VAR_COUNT) return -1;
      return int'(v);
    endfunction

    function void note_instruction(logic [4:0] mode, logic [31:0] opd, logic [31:0] rdv);
      exec_result_t r;
      int np;
      bit pushes;
      logic [31:0] a, b, v;
      int vi;
      logic [2:0] err;
      logic [15:0] nxt;
      longint sa, sbv, q;
      r = '{pc, 1'b0, 32'd0, ERR_OK};
      if (halted || mode > OP_MOD) begin
        halted = 1;
        r.error_code = ERR_HALT;
        expected_results.push_back(r);
        return;
      end
      case (mode)
        OP_PUSHL, OP_PUSHV: np = 0;
        OP_NOT, OP_JMP, OP_WRITE, OP_READ: np = 1;
        default: np = 2;
      endcase
      pushes = (mode <= OP_AND) || (mode >= OP_ADD && mode <= OP_NE) || (mode == OP_MOD);
      err = ERR_OK;
      nxt = pc + 16'd1;
      a = '0;
      b = '0;
      vi = -1;
      if (depth < np) err = ERR_UNDERFLOW;
      else if (depth - np + int'(pushes) > STACK_DEPTH) err = ERR_OVERFLOW;
      if (err == ERR_OK) begin
        if (np >= 1) a = stack_words[depth-1];
        if (np >= 2) b = stack_words[depth-2];
        if (mode == OP_PUSHV) begin
          vi = var_slot(opd);
          if (vi < 0 || !var_set[vi]) err = ERR_UNASSIGNED;
        end else if (mode == OP_READ) begin
          vi = var_slot(a);
          if (vi < 0) err = ERR_UNASSIGNED;
        end else if (mode == OP_ASSIGN) begin
          vi = var_slot(b);
          if (vi < 0) err = ERR_UNASSIGNED;
        end else if ((mode == OP_DIV || mode == OP_MOD) && a == 0) begin
          err = ERR_DIVZERO;
        end
      end
      if (err != ERR_OK) begin
        halted = 1;
        r.error_code = err;
        expected_results.push_back(r);
        return;
      end
      v = '0;
      sa = longint'($signed(a));
      sbv = longint'($signed(b));
      case (mode)
        OP_PUSHL:  v = opd;
        OP_PUSHV:  v = var_words[vi];
        OP_NOT:    v = 32'(a == 0);
        OP_OR:     v = 32'(a != 0 || b != 0);
        OP_AND:    v = 32'(a != 0 && b != 0);
        OP_JMP:    nxt = a[15:0];
        OP_JF:     if (b == 0) nxt = a[15:0];
        OP_WRITE: begin
          r.write_valid = 1'b1;
          r.write_value = a;
        end
        OP_READ: begin
          var_words[vi] = rdv;
          var_set[vi] = 1;
        end
        OP_ADD:    v = b + a;
        OP_MUL:    v = b * a;
        OP_SUB:    v = b - a;
        OP_DIV: begin
          // magnitudes in 64 bits so the most negative word needs no care
          q = (sbv < 0 ? -sbv : sbv) / (sa < 0 ? -sa : sa);
          if (a[31] != b[31]) q = -q;
          v = q[31:0];
        end
        OP_MOD: begin
          q = (sbv < 0 ? -sbv : sbv) % (sa < 0 ? -sa : sa);
          if (b[31]) q = -q;
          v = q[31:0];
        end
        OP_EQ:     v = 32'(b == a);
        OP_LT:     v = 32'($signed(b) < $signed(a));
        OP_GT:     v = 32'($signed(b) > $signed(a));
        OP_LE:     v = 32'($signed(b) <= $signed(a));
        OP_GE:     v = 32'($signed(b) >= $signed(a));
        OP_NE:     v = 32'(b != a);
        OP_ASSIGN: begin
          var_words[vi] = a;
          var_set[vi] = 1;
        end
        default: ;
      endcase
      depth -= np;
      if (pushes) begin
        stack_words[depth] = v;
        depth++;
      end
      pc = nxt;
      r.next_pc = nxt;
      expected_results.push_back(r);
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t exp_r;
      n_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result pc=%0h err=%0d", $time, got.next_pc, got.error_code);
        fails++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.write_valid) n_writes++;
      if (got.next_pc !== exp_r.next_pc) begin
        $display("%0t: next_pc expected %0h actual %0h", $time, exp_r.next_pc, got.next_pc);
        fails++;
      end
      if (got.write_valid !== exp_r.write_valid) begin
        $display("%0t: write_valid expected %0b actual %0b", $time,
                 exp_r.write_valid, got.write_valid);
        fails++;
      end
      if (got.write_value !== exp_r.write_value) begin
        $display("%0t: write_value expected %0h actual %0h", $time,
                 exp_r.write_value, got.write_value);
        fails++;
      end
      if (got.error_code !== exp_r.error_code) begin
        $display("%0t: error_code expected %0d actual %0d", $time,
                 exp_r.error_code, got.error_code);
        fails++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [4:0]         in_mode;
  logic signed [31:0] in_operand;
  logic signed [31:0] in_read_value;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_next_pc;
  logic               out_write_valid;
  logic signed [31:0] out_write_value;
  logic [2:0]         out_error_code;

  rpn_result_tracker tracker = new();
  int  cycle_count = 0;
  int  n_sent = 0;
  bit  quiet = 0;
  bit  held_off = 0;
  int  known_vars [$];

  rpn_stack_machine_execute_top dut (.*);

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("rpn_stack_machine_execute_top test failed");
    $finish;
  end

  // Result side: check every transfer, stall at random, one long hold-off
  initial begin
    int hold;
    int r;
    exec_result_t got;
    hold = 0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '{out_next_pc, out_write_valid, out_write_value, out_error_code};
        tracker.check_result(got);
      end
      if (!held_off && tracker.n_checked >= 200) begin
        held_off = 1;
        hold = 500;
      end
      r = $urandom_range(0, 99);
      if (hold == 0 && !quiet && r < 3) hold = $urandom_range(10, 40);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && (r < 25);
      end
    end
  end

  function automatic logic [31:0] rand_word();
    logic [31:0] extremes [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1};
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return extremes[$urandom_range(0, 4)];
      3: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // One instruction transfer, then a random gap
  task automatic send(logic [4:0] mode, logic [31:0] opd, logic [31:0] rdv);
    int g;
    int r;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_operand <= opd;
    in_read_value <= rdv;
    do @(posedge clk); while (in_stall);
    tracker.note_instruction(mode, opd, rdv);
    n_sent++;
    quiet = ((n_sent / 60) % 4) == 1;
    r = $urandom_range(0, 99);
    g = quiet ? 0 : (r < 60 ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40)));
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic push_lit(logic [31:0] v);
    send(OP_PUSHL, v, $urandom);
  endtask

  task automatic store_var(logic [4:0] mode, int idx, logic [31:0] v);
    push_lit(idx);
    if (mode == OP_ASSIGN) push_lit(v);
    send(mode, $urandom, v);
    known_vars.push_back(idx);
  endtask

  // One well-formed instruction, with any operands it needs pushed first
  task automatic random_instr();
    logic [4:0] mode;
    logic [31:0] d;
    mode = $urandom_range(0, 20);
    if (tracker.depth >= 110 && (mode <= OP_PUSHV || mode == OP_READ || mode == OP_ASSIGN))
      mode = OP_ADD;
    case (mode)
      OP_PUSHL: push_lit(rand_word());
      OP_PUSHV: begin
        if (known_vars.size() == 0) push_lit(rand_word());
        else send(OP_PUSHV, known_vars[$urandom_range(0, known_vars.size() - 1)], $urandom);
      end
      OP_READ, OP_ASSIGN: store_var(mode, $urandom_range(0, VAR_COUNT - 1), rand_word());
      OP_DIV, OP_MOD: begin
        if (tracker.depth < 1) push_lit(rand_word());
        if (tracker.depth < 2 || tracker.stack_words[tracker.depth-1] == 0 ||
            $urandom_range(0, 1)) begin
          d = rand_word();
          push_lit(d == 0 ? 32'd3 : d);
        end
        send(mode, $urandom, $urandom);
      end
      OP_JMP, OP_JF: begin
        if (tracker.depth < 2 || $urandom_range(0, 1)) push_lit(rand_word());
        if (tracker.depth < 2) push_lit(rand_word());
        send(mode, $urandom, $urandom);
      end
      default: begin
        while (tracker.depth < 2) push_lit(rand_word());
        send(mode, $urandom, $urandom);
      end
    endcase
  endtask

  // Drive one fault into the machine, then a few instructions it must refuse
  task automatic fault_tail();
    int idx;
    case ($urandom_range(0, 5))
      0: begin
        push_lit($urandom);
        push_lit(0);
        send($urandom_range(0, 1) ? OP_DIV : OP_MOD, 0, 0);
      end
      1: begin
        idx = 0;
        while (idx < VAR_COUNT && tracker.var_set[idx]) idx++;
        send(OP_PUSHV, idx < VAR_COUNT ? idx : VAR_COUNT, 0);
      end
      2: send($urandom_range(OP_MOD + 1, 31), $urandom, $urandom);
      3: begin
        while (tracker.depth > 0) send(OP_WRITE, 0, 0);
        send(OP_WRITE, 0, 0);
      end
      4: begin
        while (tracker.depth < STACK_DEPTH) push_lit($urandom);
        push_lit(32'd1);
      end
      default: begin
        push_lit(32'hffff_ffff);
        send(OP_READ, 0, 1);
      end
    endcase
    repeat (6) send($urandom_range(0, 31), $urandom, $urandom);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_mode = '0;
    in_operand = '0;
    in_read_value = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: wrap, division overflow, negative remainders, variables, jumps
    push_lit(32'h7fff_ffff);
    push_lit(32'h7fff_ffff);
    send(OP_ADD, 0, 0);
    push_lit(32'h8000_0000);
    push_lit(32'hffff_ffff);
    send(OP_DIV, 0, 0);
    push_lit(32'h8000_0000);
    push_lit(32'hffff_ffff);
    send(OP_MOD, 0, 0);
    push_lit(-32'sd7);
    push_lit(32'd2);
    send(OP_MOD, 0, 0);
    store_var(OP_READ, VAR_COUNT - 1, 32'hffff_ffff);
    send(OP_PUSHV, VAR_COUNT - 1, 0);
    store_var(OP_ASSIGN, 0, 32'h1234_5678);
    send(OP_PUSHV, 0, 0);
    send(OP_LT, 0, 0);
    push_lit(32'h0001_2345);
    send(OP_JMP, 0, 0);
    send(OP_NOT, 0, 0);
    push_lit(32'hffff);
    send(OP_JF, 0, 0);
    send(OP_WRITE, 0, 0);

    // Random programs, with one pass that fills the stack to the brim
    for (int k = 0; n_sent < ITEM_TARGET; k++) begin
      if (k == FILL_AT) begin
        while (tracker.depth < STACK_DEPTH) push_lit(rand_word());
        while (tracker.depth > 90) send(OP_WRITE, 0, 0);
      end
      random_instr();
    end
    fault_tail();
    in_valid <= 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran %0d instructions: all 21 operations, random operands, a full stack,",
             n_sent);
    $display("a fault and halt; %0d results checked, %0d writes.",
             tracker.n_checked, tracker.n_writes);
    if (tracker.fails == 0 && tracker.expected_results.size() == 0) begin
      $display("rpn_stack_machine_execute_top test passed");
    end else begin
      $display("rpn_stack_machine_execute_top test failed");
    end
    $finish;
  end
endmodule
